// ----- sv/rpi_pkg.sv -----
`default_nettype none

package rpi_pkg;

   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W = 3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_POINT_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NORMAL_Z = 3'd5;

   // Status that travels with each word between the pipeline sections.
   typedef struct packed {
      logic valid;
      logic ok;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ----- sv/ray_plane_intersect_top.sv -----
`default_nettype none

// Channel  Direction  Ports                  Contents
// req      in         req_tvalid/tready/data ray origin, direction, best distance
// rsp      out        rsp_tvalid/tready/data distance, hit point, local point; tuser = hit
// csr      in         csr_we/index/wdata     plane point and normal registers
//
// The pipeline has four stages of dot products, an overflow check, one stage per
// quotient bit of the restoring divider, and four stages for the hit point. One ray
// is taken every cycle while the output word is not held.
// Reset clears the stage valid bits and loads the plane registers.
// When the output word is held, the whole pipeline freezes and req_tready drops.

module ray_plane_intersect_top #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // ray_origin_x, _y, _z, ray_dir_x, _y, _z, best_distance, zero fill
   input  wire [((7*WORD_BITS-1+7)/8)*8-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // distance, hit_x, hit_y, hit_z, local_x, local_y, local_z, zero fill
   output logic [((7*WORD_BITS-1+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic                            rsp_tuser,
   input  wire                             csr_we,
   input  wire [rpi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [WORD_BITS-1:0]             csr_wdata
);

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int SIDE_W = 7 * W - 1;
   localparam int BUS_W = ((SIDE_W + 7) / 8) * 8;
   localparam int DEN_W = 2 * W + 2;
   localparam int NN_W = 2 * W + 3 + F;

   logic [W-1:0]          pp_ff [3];
   logic [W-1:0]          pn_ff [3];
   logic                  en;
   rpi_pkg::pipe_ctl_type dot_ctl, div_ctl;
   logic [NN_W-1:0]       dot_nn;
   logic [DEN_W-1:0]      dot_dmag;
   logic [SIDE_W-1:0]     dot_side, div_side;
   logic [W-2:0]          div_q;
   logic [W-2:0]          distance;
   logic [3*W-1:0]        hit_xyz, local_xyz;

   // Plane registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff[0] <= '0;
         pp_ff[1] <= '0;
         pp_ff[2] <= '0;
         pn_ff[0] <= '0;
         pn_ff[1] <= '0;
         pn_ff[2] <= W'(1) << F;
      end else if (csr_we) begin
         case (csr_index)
            rpi_pkg::CSR_PLANE_POINT_X:  pp_ff[0] <= csr_wdata;
            rpi_pkg::CSR_PLANE_POINT_Y:  pp_ff[1] <= csr_wdata;
            rpi_pkg::CSR_PLANE_POINT_Z:  pp_ff[2] <= csr_wdata;
            rpi_pkg::CSR_PLANE_NORMAL_X: pn_ff[0] <= csr_wdata;
            rpi_pkg::CSR_PLANE_NORMAL_Y: pn_ff[1] <= csr_wdata;
            rpi_pkg::CSR_PLANE_NORMAL_Z: pn_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output word is empty or being taken.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   rpi_dot #(.W(W), .F(F)) u_dot (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_tvalid),
      .in_side(req_tdata[SIDE_W-1:0]),
      .plane_p({pp_ff[2], pp_ff[1], pp_ff[0]}),
      .plane_n({pn_ff[2], pn_ff[1], pn_ff[0]}),
      .out_ctl(dot_ctl),
      .out_nn(dot_nn),
      .out_dmag(dot_dmag),
      .out_side(dot_side)
   );

   rpi_div #(.W(W), .F(F)) u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_ctl(dot_ctl),
      .in_nn(dot_nn),
      .in_dmag(dot_dmag),
      .in_side(dot_side),
      .out_ctl(div_ctl),
      .out_q(div_q),
      .out_side(div_side)
   );

   rpi_point #(.W(W), .F(F)) u_point (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_ctl(div_ctl),
      .in_q(div_q),
      .in_side(div_side),
      .plane_p({pp_ff[2], pp_ff[1], pp_ff[0]}),
      .out_valid(rsp_tvalid),
      .out_hit(rsp_tuser),
      .out_distance(distance),
      .out_hit_xyz(hit_xyz),
      .out_local_xyz(local_xyz)
   );

   assign rsp_tdata = BUS_W'({local_xyz, hit_xyz, distance});

endmodule

`default_nettype wire

// ----- sv/rpi_dot.sv -----
`default_nettype none

module rpi_dot #(
   parameter int W = 32,
   parameter int F = 16,
   localparam int SIDE_W = 7 * W - 1,
   localparam int NUM_W = 2 * W + 3,
   localparam int DEN_W = 2 * W + 2,
   localparam int NN_W = NUM_W + F
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       en,
   input  wire                       in_valid,
   input  wire [SIDE_W-1:0]          in_side,
   input  wire [3*W-1:0]             plane_p,
   input  wire [3*W-1:0]             plane_n,
   output rpi_pkg::pipe_ctl_type     out_ctl,
   output logic [NN_W-1:0]           out_nn,
   output logic [DEN_W-1:0]          out_dmag,
   output logic [SIDE_W-1:0]         out_side
);

   localparam logic [DEN_W-1:0] THR = DEN_W'((64'd1 << (2 * F)) / 64'd1000);

   logic                    a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [SIDE_W-1:0]       a_side_ff, b_side_ff, c_side_ff, d_side_ff;
   logic signed [W:0]       diff_in [3];
   logic signed [W:0]       a_diff_ff [3];
   logic signed [2*W:0]     pn_in [3];
   logic signed [2*W:0]     b_pn_ff [3];
   logic signed [2*W-1:0]   nd_in [3];
   logic signed [2*W-1:0]   b_nd_ff [3];
   logic signed [NUM_W-1:0] num_in, c_num_ff;
   logic signed [DEN_W-1:0] den_in, c_den_ff;
   logic [NUM_W-1:0]        nmag;
   logic [DEN_W-1:0]        dmag_in, d_dmag_ff;
   logic [NN_W-1:0]         d_nn_ff;
   logic                    ok_in, d_ok_ff;

   // Plane point minus ray origin, one bit wider than a word.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = $signed({plane_p[i*W+W-1], plane_p[i*W +: W]})
                    - $signed({in_side[i*W+W-1], in_side[i*W +: W]});
      end
   end

   // Products of both dot products, one multiplier per term.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pn_in[i] = a_diff_ff[i] * $signed(plane_n[i*W +: W]);
         nd_in[i] = $signed(plane_n[i*W +: W]) * $signed(a_side_ff[(3+i)*W +: W]);
      end
   end

   // Exact sums of the three terms.
   assign num_in = NUM_W'(b_pn_ff[0]) + NUM_W'(b_pn_ff[1]) + NUM_W'(b_pn_ff[2]);
   assign den_in = DEN_W'(b_nd_ff[0]) + DEN_W'(b_nd_ff[1]) + DEN_W'(b_nd_ff[2]);

   // Magnitudes, sign agreement and the small-denominator test.
   assign nmag    = c_num_ff[NUM_W-1] ? NUM_W'(-c_num_ff) : NUM_W'(c_num_ff);
   assign dmag_in = c_den_ff[DEN_W-1] ? DEN_W'(-c_den_ff) : DEN_W'(c_den_ff);
   assign ok_in   = (dmag_in > THR) && (c_num_ff[NUM_W-1] == c_den_ff[DEN_W-1])
                 && (c_num_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= in_side;
         b_side_ff <= a_side_ff;
         c_side_ff <= b_side_ff;
         d_side_ff <= c_side_ff;
         for (int i = 0; i < 3; i++) begin
            a_diff_ff[i] <= diff_in[i];
            b_pn_ff[i]   <= pn_in[i];
            b_nd_ff[i]   <= nd_in[i];
         end
         c_num_ff  <= num_in;
         c_den_ff  <= den_in;
         d_nn_ff   <= {nmag, {F{1'b0}}};
         d_dmag_ff <= dmag_in;
         d_ok_ff   <= ok_in;
      end
   end

   assign out_ctl.valid = d_valid_ff;
   assign out_ctl.ok    = d_ok_ff;
   assign out_nn        = d_nn_ff;
   assign out_dmag      = d_dmag_ff;
   assign out_side      = d_side_ff;

endmodule

`default_nettype wire

// ----- sv/rpi_div_step.sv -----
`default_nettype none

module rpi_div_step #(
   parameter int CW = 100,
   parameter int DEN_W = 66,
   parameter int QW = 31,
   parameter int SHIFT = 0,
   parameter int BW = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  wire               in_valid,
   input  wire [CW-1:0]      in_rem,
   input  wire [DEN_W-1:0]   in_den,
   input  wire [QW-1:0]      in_q,
   input  wire [BW-1:0]      in_bundle,
   output logic              out_valid,
   output logic [CW-1:0]     out_rem,
   output logic [DEN_W-1:0]  out_den,
   output logic [QW-1:0]     out_q,
   output logic [BW-1:0]     out_bundle
);

   logic [CW-1:0] dsh;
   logic          take;
   logic [CW-1:0] rem_in;
   logic [QW-1:0] q_in;

   // One restoring step: subtract the shifted divisor where it fits.
   always_comb begin
      dsh         = CW'(in_den) << SHIFT;
      take        = in_rem >= dsh;
      rem_in      = take ? (in_rem - dsh) : in_rem;
      q_in        = in_q;
      q_in[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_rem    <= rem_in;
         out_den    <= in_den;
         out_q      <= q_in;
         out_bundle <= in_bundle;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rpi_div.sv -----
`default_nettype none

module rpi_div #(
   parameter int W = 32,
   parameter int F = 16,
   localparam int SIDE_W = 7 * W - 1,
   localparam int DEN_W = 2 * W + 2,
   localparam int NN_W = 2 * W + 3 + F
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  rpi_pkg::pipe_ctl_type  in_ctl,
   input  wire [NN_W-1:0]         in_nn,
   input  wire [DEN_W-1:0]        in_dmag,
   input  wire [SIDE_W-1:0]       in_side,
   output rpi_pkg::pipe_ctl_type  out_ctl,
   output logic [W-2:0]           out_q,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int CW = ((NN_W > DEN_W + W) ? NN_W : DEN_W + W) + 1;
   localparam int QW = W - 1;
   localparam int BW = SIDE_W + 1;

   logic              valid_c [W];
   logic [CW-1:0]     rem_c [W];
   logic [DEN_W-1:0]  den_c [W];
   logic [QW-1:0]     q_c [W];
   logic [BW-1:0]     bundle_c [W];
   logic              ovf;

   // A quotient at or above the top of the word range saturates and can
   // never beat the best distance, so it is a miss.
   assign ovf = CW'(in_nn) >= (CW'(in_dmag) << (W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c[0] <= 1'b0;
      end else if (en) begin
         valid_c[0] <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_c[0]    <= CW'(in_nn);
         den_c[0]    <= in_dmag;
         q_c[0]      <= '0;
         bundle_c[0] <= {in_ctl.ok & ~ovf, in_side};
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < W - 1; k++) begin : g_step
      rpi_div_step #(
         .CW(CW),
         .DEN_W(DEN_W),
         .QW(QW),
         .SHIFT(W - 2 - k),
         .BW(BW)
      ) u_step (
         .clock(clock),
         .reset(reset),
         .en(en),
         .in_valid(valid_c[k]),
         .in_rem(rem_c[k]),
         .in_den(den_c[k]),
         .in_q(q_c[k]),
         .in_bundle(bundle_c[k]),
         .out_valid(valid_c[k+1]),
         .out_rem(rem_c[k+1]),
         .out_den(den_c[k+1]),
         .out_q(q_c[k+1]),
         .out_bundle(bundle_c[k+1])
      );
   end

   assign out_ctl.valid = valid_c[W-1];
   assign out_ctl.ok    = bundle_c[W-1][BW-1];
   assign out_q         = q_c[W-1];
   assign out_side      = bundle_c[W-1][SIDE_W-1:0];

endmodule

`default_nettype wire

// ----- sv/rpi_point.sv -----
`default_nettype none

module rpi_point #(
   parameter int W = 32,
   parameter int F = 16,
   localparam int SIDE_W = 7 * W - 1
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  rpi_pkg::pipe_ctl_type  in_ctl,
   input  wire [W-2:0]            in_q,
   input  wire [SIDE_W-1:0]       in_side,
   input  wire [3*W-1:0]          plane_p,
   output logic                   out_valid,
   output logic                   out_hit,
   output logic [W-2:0]           out_distance,
   output logic [3*W-1:0]         out_hit_xyz,
   output logic [3*W-1:0]         out_local_xyz
);

   logic                  e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff;
   logic                  e_hit_ff, f_hit_ff, g_hit_ff, h_hit_ff;
   logic [W-2:0]          e_t_ff, f_t_ff, g_t_ff, h_t_ff;
   logic [3*W-1:0]        e_o_ff, f_o_ff;
   logic [3*W-1:0]        e_d_ff;
   logic                  hit_in;
   logic signed [2*W-1:0] prod_in [3];
   logic signed [2*W-1:0] f_prod_ff [3];
   logic signed [2*W-1:0] shifted [3];
   logic signed [2*W:0]   sum [3];
   logic [W-1:0]          h_in [3];
   logic [W-1:0]          g_h_ff [3];
   logic signed [W:0]     lsub [3];
   logic [W-1:0]          l_in [3];
   logic [W-1:0]          h_h_ff [3];
   logic [W-1:0]          h_l_ff [3];

   function automatic logic [W-1:0] sat_wide(input logic [2*W:0] x);
      logic [W-1:0] r;
      if (!x[2*W] && (|x[2*W-1:W-1])) begin
         r = {1'b0, {(W-1){1'b1}}};
      end else if (x[2*W] && !(&x[2*W-1:W-1])) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

   function automatic logic [W-1:0] sat_one(input logic [W:0] x);
      logic [W-1:0] r;
      if (x[W] != x[W-1]) begin
         r = x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

   // Hit test on the quotient against the best distance.
   assign hit_in = in_ctl.ok && (in_q != '0) && (in_q < in_side[SIDE_W-1 -: W-1]);

   // t times direction, then floor shift plus origin, then minus plane point.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed({1'b0, e_t_ff}) * $signed(e_d_ff[i*W +: W]);
         shifted[i] = f_prod_ff[i] >>> F;
         sum[i]     = $signed({shifted[i][2*W-1], shifted[i]})
                    + $signed({{(W+1){f_o_ff[i*W+W-1]}}, f_o_ff[i*W +: W]});
         h_in[i]    = sat_wide(sum[i]);
         lsub[i]    = $signed({g_h_ff[i][W-1], g_h_ff[i]})
                    - $signed({plane_p[i*W+W-1], plane_p[i*W +: W]});
         l_in[i]    = sat_one(lsub[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= in_ctl.valid;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_hit_ff <= hit_in;
         e_t_ff   <= in_q;
         e_o_ff   <= in_side[3*W-1:0];
         e_d_ff   <= in_side[6*W-1:3*W];
         f_hit_ff <= e_hit_ff;
         f_t_ff   <= e_t_ff;
         f_o_ff   <= e_o_ff;
         g_hit_ff <= f_hit_ff;
         g_t_ff   <= f_t_ff;
         h_hit_ff <= g_hit_ff;
         h_t_ff   <= g_hit_ff ? g_t_ff : '0;
         for (int i = 0; i < 3; i++) begin
            f_prod_ff[i] <= prod_in[i];
            g_h_ff[i]    <= h_in[i];
            h_h_ff[i]    <= g_hit_ff ? g_h_ff[i] : '0;
            h_l_ff[i]    <= g_hit_ff ? l_in[i] : '0;
         end
      end
   end

   assign out_valid     = h_valid_ff;
   assign out_hit       = h_hit_ff;
   assign out_distance  = h_t_ff;
   assign out_hit_xyz   = {h_h_ff[2], h_h_ff[1], h_h_ff[0]};
   assign out_local_xyz = {h_l_ff[2], h_l_ff[1], h_l_ff[0]};

endmodule

`default_nettype wire

// ----- tb/tb_ray_plane_intersect_top.sv -----
`timescale 1ns / 1ps

module tb_ray_plane_intersect_top;

   localparam int FB = 16;
   localparam int WB = 32;
   localparam int DW = ((7*WB-1+7)/8)*8;
   localparam int LATENCY = WB + 8;
   localparam int N_RANDOM = 1030;
   localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

   typedef struct packed {
      logic [WB-2:0]   best;
      logic [WB-1:0]   dz, dy, dx, oz, oy, ox;
   } ray_word_type;

   typedef struct {
      logic          hit;
      logic [WB-2:0] distance;
      logic [WB-1:0] hx, hy, hz, lx, ly, lz;
   } isect_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   wire  req_tready;
   logic [DW-1:0] req_tdata = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 0;
   wire  [DW-1:0] rsp_tdata;
   wire  rsp_tuser;
   logic csr_we = 0;
   logic [rpi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [WB-1:0] csr_wdata = '0;

   ray_plane_intersect_top #(.FRAC_BITS(FB), .WORD_BITS(WB)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Plane registers as the checker sees them.
   logic signed [WB-1:0] plane_pt [3];
   logic signed [WB-1:0] plane_n [3];

   ray_word_type pending_rays[$];
   isect_type    expected_isects[$];
   int        mismatches = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        recv_hold = 0;

   function automatic logic signed [WB-1:0] clamp_word(logic signed [127:0] v);
      if (v > 128'(signed'(WMAX))) return WMAX;
      if (v < 128'(signed'(WMIN))) return WMIN;
      return v[WB-1:0];
   endfunction

   // Exact dot products, a truncated quotient, and saturated hit points.
   function automatic isect_type intersect_ray(ray_word_type r);
      isect_type res;
      logic signed [127:0] num, den, nmag, dmag, q, tq, prod;
      logic signed [WB-1:0] o [3];
      logic signed [WB-1:0] d [3];
      logic signed [WB-1:0] h;
      logic signed [127:0] thr;
      res = '{default: '0};
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
         num += (128'(plane_pt[i]) - 128'(o[i])) * 128'(plane_n[i]);
         den += 128'(plane_n[i]) * 128'(d[i]);
      end
      thr = (128'sd1 << (2*FB)) / 1000;
      nmag = num < 0 ? -num : num;
      dmag = den < 0 ? -den : den;
      if (dmag > thr && (num < 0) == (den < 0) && num != 0) begin
         q = (nmag <<< FB) / dmag;
         tq = q > 128'(signed'(WMAX)) ? 128'(signed'(WMAX)) : q;
         if (tq > 0 && tq < 128'(r.best)) begin
            res.hit = 1;
            res.distance = tq[WB-2:0];
            for (int i = 0; i < 3; i++) begin
               prod = tq * 128'(d[i]);
               h = clamp_word((prod >>> FB) + 128'(o[i]));
               case (i)
                  0: begin res.hx = h; res.lx = clamp_word(128'(h) - 128'(plane_pt[0])); end
                  1: begin res.hy = h; res.ly = clamp_word(128'(h) - 128'(plane_pt[1])); end
                  default: begin
                     res.hz = h;
                     res.lz = clamp_word(128'(h) - 128'(plane_pt[2]));
                  end
               endcase
            end
         end
      end
      return res;
   endfunction

   // Driver: offers the next pending ray, idling at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_isects.push_back(intersect_ray(pending_rays.pop_front()));
         end
         if ((!req_tvalid || req_tready)) begin
            if (pending_rays.size() > 0 && !(req_tvalid && req_tready && pending_rays.size() == 0)
                && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= DW'(pending_rays[0]);
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Monitor: compares each result word against the oldest expectation.
   always @(posedge clock) begin
      isect_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_isects.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
            end else begin
               e = expected_isects.pop_front();
               if (rsp_tuser !== e.hit || rsp_tdata[WB-2:0] !== e.distance
                   || rsp_tdata[WB-1 +: WB] !== e.hx || rsp_tdata[2*WB-1 +: WB] !== e.hy
                   || rsp_tdata[3*WB-1 +: WB] !== e.hz || rsp_tdata[4*WB-1 +: WB] !== e.lx
                   || rsp_tdata[5*WB-1 +: WB] !== e.ly || rsp_tdata[6*WB-1 +: WB] !== e.lz
                   || rsp_tdata[DW-1:7*WB-1] !== '0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected hit=%0d dist=%h h=%h %h %h l=%h %h %h,",
                               " got hit=%0d word=%h"},
                              e.hit, e.distance, e.hx, e.hy, e.hz, e.lx, e.ly, e.lz,
                              rsp_tuser, rsp_tdata);
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   task automatic write_reg(logic [rpi_pkg::CSR_IDX_W-1:0] idx, logic [WB-1:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx <= rpi_pkg::CSR_PLANE_POINT_Z) plane_pt[idx] = val;
      else plane_n[idx - rpi_pkg::CSR_PLANE_NORMAL_X] = val;
   endtask

   task automatic drain;
      while (pending_rays.size() > 0 || req_tvalid || expected_isects.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [WB-1:0] rand_word();
      case ($urandom_range(5))
         0: return WMAX;
         1: return WMIN;
         2: return WB'(signed'($urandom_range(2 << FB)) - (1 << FB));
         3: return WB'(signed'($urandom_range(200 << FB)) - (100 << FB));
         default: return $urandom;
      endcase
   endfunction

   // Rays from random words: extremes, small and modest ranges, and raw noise.
   function automatic ray_word_type rand_ray();
      ray_word_type r;
      r.ox = rand_word(); r.oy = rand_word(); r.oz = rand_word();
      r.dx = rand_word(); r.dy = rand_word(); r.dz = rand_word();
      case ($urandom_range(3))
         0: r.best = {(WB-1){1'b1}};
         1: r.best = $urandom;
         default: r.best = (WB-1)'($urandom_range(300 << FB));
      endcase
      return r;
   endfunction

   task automatic load_plane(logic [WB-1:0] px, py, pz, nx, ny, nz);
      write_reg(rpi_pkg::CSR_PLANE_POINT_X, px);
      write_reg(rpi_pkg::CSR_PLANE_POINT_Y, py);
      write_reg(rpi_pkg::CSR_PLANE_POINT_Z, pz);
      write_reg(rpi_pkg::CSR_PLANE_NORMAL_X, nx);
      write_reg(rpi_pkg::CSR_PLANE_NORMAL_Y, ny);
      write_reg(rpi_pkg::CSR_PLANE_NORMAL_Z, nz);
   endtask

   initial begin
      ray_word_type r;
      plane_pt[0] = 0; plane_pt[1] = 0; plane_pt[2] = 0;
      plane_n[0] = 0; plane_n[1] = 0; plane_n[2] = 1 << FB;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed rays against the reset plane z = 0.
      send_idle_pct = 15;
      recv_idle_pct = 85;
      r = '{best: {(WB-1){1'b1}}, oz: 32'sd5 << FB, dz: -(32'sd1 << FB), default: '0};
      pending_rays.push_back(r);                       // plain hit at t = 5
      r.best = (WB-1)'(5 << FB);  pending_rays.push_back(r); // t equal to best: miss
      r.best = (WB-1)'(0);        pending_rays.push_back(r); // zero best
      r.best = {(WB-1){1'b1}};
      r.dz = 32'sd1 << FB;        pending_rays.push_back(r); // pointing away
      r.dz = 0;                   pending_rays.push_back(r); // parallel
      r.dz = -32'sd65;            pending_rays.push_back(r); // n.d just under threshold
      r.dz = -32'sd66;            pending_rays.push_back(r); // just over
      r.dz = -32'sd1;             pending_rays.push_back(r); // tiny denominator
      r.oz = 0; r.dz = -(32'sd1 << FB); pending_rays.push_back(r); // origin on plane
      r.oz = WMAX; r.dz = -32'sd70; pending_rays.push_back(r); // huge t saturates
      r.oz = 32'sd1 << FB; r.dz = -(32'sd1 << FB); r.dx = WMAX; r.dy = WMIN;
      r.ox = WMAX; r.oy = WMIN;   pending_rays.push_back(r); // saturating hit point
      r = '{ox: WMIN, oy: WMAX, oz: WMIN, dx: WMIN, dy: WMAX, dz: WMAX,
            best: {(WB-1){1'b1}}};
      pending_rays.push_back(r);
      r = '{ox: '1, oy: '1, oz: '1, dx: '1, dy: '1, dz: '1, best: '1};
      pending_rays.push_back(r);
      drain();

      // Zero normal: every ray misses.
      load_plane(0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++) pending_rays.push_back(rand_ray());
      drain();

      // Extreme plane, long receiver stall while the sender keeps offering.
      load_plane(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN);
      send_idle_pct = 85;
      recv_idle_pct = 15;
      recv_hold = 150;
      for (int i = 0; i < 300; i++) pending_rays.push_back(rand_ray());
      drain();

      // Random planes, random rays.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = ph < 2 ? 85 : 0;
         recv_idle_pct = ph < 2 ? 15 : 0;
         load_plane(rand_word(), rand_word(), rand_word(),
                    $urandom_range(1) ? rand_word() : (1 << FB),
                    rand_word(), rand_word());
         for (int i = 0; i < (N_RANDOM - 300) / 4; i++) pending_rays.push_back(rand_ray());
         drain();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- ray_plane_intersect_top.f -----
sv/rpi_pkg.sv
sv/rpi_dot.sv
sv/rpi_div_step.sv
sv/rpi_div.sv
sv/rpi_point.sv
sv/ray_plane_intersect_top.sv
tb/tb_ray_plane_intersect_top.sv
